FILE: rtl/sdq_pkg.sv
// Shared widths, request and status codes, and the result type of the sorted deadline queue.
package sdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int KEY_W     = 32;
  localparam int ID_PORT_W = 8;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXTRACT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_PORT_W-1:0] rid;
    logic [KEY_W-1:0]     rkey;
  } sdq_res_t;

endpackage

FILE: rtl/sdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sdq_seq.sv
// Sequencer that walks the sorted list in RAM, one entry per read and compare step.
module sdq_seq #(
  parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = sdq_pkg::ID_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sdq_pkg::REQ_W-1:0]   req_type,
  input  logic [sdq_pkg::KEY_W-1:0]   sort_key,
  input  logic [ID_BITS-1:0]          entry_id,
  output logic                        ready,
  output logic                        res_valid,
  input  logic                        res_ready,
  output sdq_pkg::sdq_res_t           res
);
  import sdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = KEY_W + ID_BITS;
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW-1:0] FULL_C = CW'(QUEUE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_INS_WR  = 9'b000001000,
    S_FND_RD  = 9'b000010000,
    S_FND_CMP = 9'b000100000,
    S_SH_RD   = 9'b001000000,
    S_SH_CMP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [STATUS_W-1:0]  st_r, st_nxt;
  logic [ID_PORT_W-1:0] rid_r, rid_nxt;
  logic [KEY_W-1:0]     rkey_r, rkey_nxt;

  logic                 wen;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        rdata;
  logic [KEY_W-1:0]     rd_key;
  logic [ID_BITS-1:0]   rd_id;
  logic [CW-1:0]        ptr_p1;
  logic [CW-1:0]        ptr_m1;
  logic                 key_ge;
  logic                 id_hit;

  sdq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key = rdata[KEY_W-1:0];
  assign rd_id  = rdata[KEY_W +: ID_BITS];
  assign ptr_p1 = ptr_r + ONE_C;
  assign ptr_m1 = ptr_r - ONE_C;
  // Two compares: key order for inserts, handle match for removes (an extract takes the first entry).
  assign key_ge = (rd_key >= key_r);
  assign id_hit = (req_r == REQ_EXTRACT) || (rd_id == id_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    req_nxt   = req_r;
    key_nxt   = key_r;
    id_nxt    = id_r;
    st_nxt    = st_r;
    rid_nxt   = rid_r;
    rkey_nxt  = rkey_r;
    wen       = 1'b0;
    waddr     = ptr_r[AW-1:0];
    wdata     = {id_r, key_r};
    raddr     = ptr_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = req_type;
          key_nxt  = sort_key;
          id_nxt   = entry_id;
          st_nxt   = ST_OK;
          rid_nxt  = '0;
          rkey_nxt = '0;
          ptr_nxt  = '0;
          case (req_type)
            REQ_INSERT: begin
              if (cnt_r == FULL_C) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = S_INS_WR;
              end else begin
                // Walk from the tail toward the head, moving larger and equal keys up.
                ptr_nxt   = cnt_r - ONE_C;
                state_nxt = S_INS_RD;
              end
            end
            REQ_EXTRACT: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FND_RD;
              end
            end
            REQ_REMOVE: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_NOT_FOUND;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FND_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        wen   = 1'b1;
        waddr = ptr_p1[AW-1:0];
        if (key_ge) begin
          wdata = rdata;
          if (ptr_r == '0) begin
            state_nxt = S_INS_WR;
          end else begin
            ptr_nxt   = ptr_m1;
            state_nxt = S_INS_RD;
          end
        end else begin
          cnt_nxt   = cnt_r + ONE_C;
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        wen       = 1'b1;
        cnt_nxt   = cnt_r + ONE_C;
        state_nxt = S_DONE;
      end
      S_FND_RD: begin
        state_nxt = S_FND_CMP;
      end
      S_FND_CMP: begin
        if (id_hit) begin
          rid_nxt  = ID_PORT_W'(rd_id);
          rkey_nxt = rd_key;
          ptr_nxt  = ptr_p1;
          if (ptr_p1 >= cnt_r) begin
            cnt_nxt   = cnt_r - ONE_C;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (ptr_p1 == cnt_r) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          ptr_nxt   = ptr_p1;
          state_nxt = S_FND_RD;
        end
      end
      S_SH_RD: begin
        state_nxt = S_SH_CMP;
      end
      S_SH_CMP: begin
        // Close the gap: the entry read here moves one place toward the head.
        wen     = 1'b1;
        waddr   = ptr_m1[AW-1:0];
        wdata   = rdata;
        ptr_nxt = ptr_p1;
        if (ptr_p1 == cnt_r) begin
          cnt_nxt   = cnt_r - ONE_C;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    ptr_r  <= ptr_nxt;
    req_r  <= req_nxt;
    key_r  <= key_nxt;
    id_r   <= id_nxt;
    st_r   <= st_nxt;
    rid_r  <= rid_nxt;
    rkey_r <= rkey_nxt;
  end

  assign ready      = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.status = st_r;
  assign res.rid    = rid_r;
  assign res.rkey   = rkey_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_C)
    else $error("entry count above queue depth");

  a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
    wen |-> (state_r == S_INS_CMP || state_r == S_INS_WR || state_r == S_SH_CMP))
    else $error("RAM write outside a write step");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_FULL) |-> (cnt_r == FULL_C))
    else $error("full status reported on a list with room");

  a_cnt_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && !$stable(cnt_r)) |-> (state_r == S_DONE))
    else $error("entry count changed before the request finished");
`endif

endmodule

FILE: rtl/sorted_deadline_queue_unit.sv
// Top level of the sorted deadline queue: stream ports, request sequencer and output register.
//
//  channel | direction | tdata fields (low bit up)         | tuser
//  in_     | slave     | sort_key[31:0], entry_id[39:32]   | req_type[1:0]
//  out_    | master    | out_id[7:0], out_key[39:8]        | status[1:0]
//
// Each request word visits list entries one at a time, because the list sits in one
// RAM with one read port and a registered read: a read step fetches an entry and a
// compare step checks it and writes it back. A new request word is taken only once
// the last one has handed its result on. A refused insert, an extract from an empty
// list and an unused request code go straight to the result.
// Reset clears the sequencer state, the entry count and the output valid flag; the RAM needs no clearing pass.
// A finished result waits in the output register while the next request word is
// taken; a stalled output holds up the sequencer only when a second result is ready.
module sorted_deadline_queue_unit #(
  parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = sdq_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sdq_pkg::IN_DATA_W-1:0]    in_tdata,   // sort_key, entry_id
  input  logic [sdq_pkg::REQ_W-1:0]        in_tuser,   // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sdq_pkg::OUT_DATA_W-1:0]   out_tdata,  // out_id, out_key
  output logic [sdq_pkg::STATUS_W-1:0]     out_tuser   // status
);
  import sdq_pkg::*;

  logic                 start;
  logic                 seq_ready;
  logic                 res_valid;
  logic                 res_ready;
  sdq_res_t             res;
  logic [ID_BITS-1:0]   req_id;

  logic                 out_valid_r, out_valid_nxt;
  sdq_res_t             out_res_r, out_res_nxt;

  // Handles are taken modulo the stored handle width.
  assign req_id    = ID_BITS'(in_tdata[KEY_W +: ID_PORT_W]);
  assign in_tready = seq_ready;
  assign start     = in_tvalid && seq_ready;

  sdq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_tuser),
    .sort_key  (in_tdata[KEY_W-1:0]),
    .entry_id  (req_id),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register can take a new result when empty or when it drains this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.rkey, out_res_r.rid};
  assign out_tuser  = out_res_r.status;

endmodule
